@@ hw/rtl/aol_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aol_pkg
// Shared constants and controller/datapath handshake types for the looper.
// ----------------------------------------------------------------------------
package aol_pkg;

   localparam int DEF_MAX_SAMPLES = 65536;
   localparam int DEF_SAMPLE_BITS = 16;

   // Mix gain 0.707 as Q0.15, rounding half up before the shift
   localparam int MIX_COEF  = 23167;
   localparam int MIX_SHIFT = 15;
   localparam int MIX_ROUND = 16384;

   localparam int LAYER_BITS = 8;
   localparam logic [LAYER_BITS-1:0] LAYER_MAX = 8'hFF;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;      // capture the transaction and update loop state
      logic clear_step;  // zero one entry of both stores
      logic mix_step;    // read one entry pair for the overdub mix
      logic rd_issue;    // read the loop entry for playback
      logic out_load;    // load the result register
   } aol_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic erase_req;   // pending transaction carries erase
      logic mix_req;     // pending transaction needs an overdub pass
      logic clear_last;  // clear counter at the final entry
      logic mix_last;    // mix counter at the final entry
      logic out_free;    // result register can take a new result
   } aol_stat_type;

endpackage

@@ hw/rtl/aol_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aol_if
// Request and response channel interfaces, valid/ready handshake.
// ----------------------------------------------------------------------------
interface aol_req_if import aol_pkg::*; #(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   logic                          stop_cmd;
   logic                          record_cmd;
   logic                          erase_cmd;

   modport source (output valid, output sample_in, output stop_cmd,
                   output record_cmd, output erase_cmd, input ready);
   modport sink   (input valid, input sample_in, input stop_cmd,
                   input record_cmd, input erase_cmd, output ready);
endinterface

interface aol_rsp_if import aol_pkg::*; #(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_sample;
   logic                          is_recording;
   logic [LAYER_BITS-1:0]         layers_done;

   modport source (output valid, output out_sample, output is_recording,
                   output layers_done, input ready);
   modport sink   (input valid, input out_sample, input is_recording,
                   input layers_done, output ready);
endinterface

@@ hw/rtl/audio_overdub_looper_unit.sv @@
`timescale 1ns / 1ps
// Sequence: a plain tick is accepted, then the loop store is read for playback and
//   the result register is loaded once it is free; a stop with a nonzero overlap
//   first runs the overdub pass over min(take length, loop length) entries and a
//   drain step, an erase first runs the clearing pass over all MAX_SAMPLES entries.
// Handshake: a new transaction is taken only after the previous result is loaded.
// Reset: synchronous; a clearing pass over all MAX_SAMPLES entries follows with req_ready low.
// ----------------------------------------------------------------------------
// audio_overdub_looper_unit
// Overdub looper: records takes, mixes them into a loop and plays it back
// mixed with the live input, one result per input transaction.
// ----------------------------------------------------------------------------
module audio_overdub_looper_unit import aol_pkg::*; #(
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic       clock,
   input  logic       reset,
   aol_req_if.sink    req_ch,
   aol_rsp_if.source  rsp_ch
);

   aol_cmd_type  cmd;
   aol_stat_type stat;

   logic                          rsp_valid;
   logic signed [SAMPLE_BITS-1:0] out_sample;
   logic                          is_recording;
   logic [LAYER_BITS-1:0]         layers_done;

   // Controller: walks each transaction through the clearing pass (erase),
   // the overdub pass (stop), the playback read and the result load. It
   // takes a new transaction only from its idle state.
   aol_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: holds both sample stores, loop/take lengths, the layer count,
   // the play position and the result register. The result register lets
   // the next transaction in while an earlier result still waits.
   aol_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .sample_in    (req_ch.sample_in),
      .stop_cmd     (req_ch.stop_cmd),
      .record_cmd   (req_ch.record_cmd),
      .erase_cmd    (req_ch.erase_cmd),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ch.ready),
      .out_sample   (out_sample),
      .is_recording (is_recording),
      .layers_done  (layers_done)
   );

   // Drive the response channel straight from the result register
   assign rsp_ch.valid        = rsp_valid;
   assign rsp_ch.out_sample   = out_sample;
   assign rsp_ch.is_recording = is_recording;
   assign rsp_ch.layers_done  = layers_done;

endmodule

@@ hw/rtl/aol_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aol_ctrl
// Sequencer: accept, clearing pass, overdub pass, playback read, result load.
// ----------------------------------------------------------------------------
module aol_ctrl import aol_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  aol_stat_type stat,
   output aol_cmd_type  cmd
);

   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_CLEAR = 3'd2;
   localparam logic [2:0] S_MIX   = 3'd3;
   localparam logic [2:0] S_DRAIN = 3'd4;
   localparam logic [2:0] S_READ  = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_INIT: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (stat.erase_req)    state_in = S_CLEAR;
               else if (stat.mix_req) state_in = S_MIX;
               else                   state_in = S_READ;
            end
         end
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) state_in = S_READ;
         end
         S_MIX: begin
            cmd.mix_step = 1'b1;
            if (stat.mix_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            // let the last mixed entry land before the playback read
            state_in = S_READ;
         end
         S_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_INIT;
      else       state_ff <= state_in;
   end

endmodule

@@ hw/rtl/aol_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aol_datapath
// Loop and take stores, length and position registers, shared mixer, result.
// ----------------------------------------------------------------------------
module aol_datapath import aol_pkg::*; #(
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  aol_cmd_type                   cmd,
   output aol_stat_type                  stat,
   input  logic signed [SAMPLE_BITS-1:0] sample_in,
   input  logic                          stop_cmd,
   input  logic                          record_cmd,
   input  logic                          erase_cmd,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] out_sample,
   output logic                          is_recording,
   output logic [LAYER_BITS-1:0]         layers_done
);

   localparam int AW  = $clog2(MAX_SAMPLES);
   localparam int LW  = $clog2(MAX_SAMPLES + 1);
   localparam int PW  = $clog2(4 * MAX_SAMPLES);
   localparam int PRW = SAMPLE_BITS + 17;

   localparam logic [LW-1:0] MAX_LEN  = LW'(MAX_SAMPLES);
   localparam logic [PW-1:0] POS_MAX  = PW'(4 * MAX_SAMPLES - 1);
   localparam logic [AW-1:0] CLR_LAST = AW'(MAX_SAMPLES - 1);

   // 0.707 * (a + b), round half up, saturate
   function automatic logic signed [SAMPLE_BITS-1:0] mix_f(
      input logic signed [SAMPLE_BITS-1:0] a,
      input logic signed [SAMPLE_BITS-1:0] b
   );
      logic signed [SAMPLE_BITS:0]   sum;
      logic signed [PRW-1:0]         prod;
      logic signed [SAMPLE_BITS+1:0] q;
      logic signed [SAMPLE_BITS-1:0] res;
      sum  = (SAMPLE_BITS+1)'(a) + (SAMPLE_BITS+1)'(b);
      prod = PRW'(sum) * PRW'(MIX_COEF) + PRW'(MIX_ROUND);
      q    = prod[PRW-1:MIX_SHIFT];
      if (q[SAMPLE_BITS+1:SAMPLE_BITS-1] != {3{q[SAMPLE_BITS+1]}}) begin
         res = q[SAMPLE_BITS+1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else begin
         res = q[SAMPLE_BITS-1:0];
      end
      return res;
   endfunction

   // stores
   logic signed [SAMPLE_BITS-1:0] loop_mem [MAX_SAMPLES];
   logic signed [SAMPLE_BITS-1:0] take_mem [MAX_SAMPLES];

   // control state
   logic [LW-1:0]         loop_len_ff,   loop_len_in;
   logic [LW-1:0]         take_len_ff,   take_len_in;
   logic [LW-1:0]         take_limit_ff, take_limit_in;
   logic [LAYER_BITS-1:0] layer_ff,      layer_in;
   logic                  rec_ff,        rec_in;
   logic [PW-1:0]         pos_ff,        pos_in;
   logic [AW-1:0]         clr_idx_ff;
   logic [AW-1:0]         mix_idx_ff;
   logic                  mix_pend_ff;
   logic                  rsp_valid_ff;

   // payload registers
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic                          out_en_ff,   out_en_in;
   logic [AW-1:0]                 rd_addr_ff,  rd_addr_in;
   logic [AW-1:0]                 mix_last_ff, mix_last_in;
   logic [AW-1:0]                 mix_wr_idx_ff;
   logic signed [SAMPLE_BITS-1:0] loop_q_ff;
   logic signed [SAMPLE_BITS-1:0] take_q_ff;
   logic signed [SAMPLE_BITS-1:0] out_sample_ff;
   logic                          out_rec_ff;
   logic [LAYER_BITS-1:0]         out_layers_ff;

   logic                          append;
   logic [LW-1:0]                 take_app;
   logic [LW-1:0]                 mix_n;
   logic [LW-1:0]                 mix_nm1;
   logic [PW-1:0]                 pos_m1;
   logic                          mix_req;
   logic signed [SAMPLE_BITS-1:0] mix_a, mix_b, mix_q;

   // next state of one tick: append, stop, record, erase, playback
   always_comb begin
      append        = rec_ff && (take_len_ff < MAX_LEN);
      take_app      = append ? take_len_ff + 1'b1 : take_len_ff;
      if (rec_ff && (layer_ff > LAYER_BITS'(1)) && (take_app >= take_limit_ff))
         take_app = '0;

      take_len_in   = take_app;
      loop_len_in   = loop_len_ff;
      take_limit_in = take_limit_ff;
      layer_in      = layer_ff;
      rec_in        = rec_ff;
      pos_in        = pos_ff;
      mix_n         = '0;

      if (stop_cmd) begin
         rec_in = 1'b0;
         pos_in = '0;
         if (layer_ff != LAYER_MAX) layer_in = layer_ff + 1'b1;
         if (layer_in == LAYER_BITS'(1)) begin
            take_limit_in = take_app;
            loop_len_in   = take_app;
         end
         mix_n       = (take_app < loop_len_in) ? take_app : loop_len_in;
         take_len_in = '0;
      end

      if (record_cmd) rec_in = 1'b1;

      if (erase_cmd) begin
         layer_in      = '0;
         take_limit_in = '0;
      end

      if (pos_in < POS_MAX) pos_in = pos_in + 1'b1;
      if ((loop_len_in >= LW'(2)) && (pos_in >= PW'(loop_len_in))) pos_in = '0;

      out_en_in   = (pos_in != '0) && (pos_in <= PW'(loop_len_in));
      pos_m1      = pos_in - 1'b1;
      rd_addr_in  = pos_m1[AW-1:0];
      mix_nm1     = mix_n - 1'b1;
      mix_last_in = mix_nm1[AW-1:0];
      mix_req     = stop_cmd && !erase_cmd && (mix_n != '0);
   end

   // shared mixer: overdub write-back or playback output
   assign mix_a = mix_pend_ff ? loop_q_ff : sample_ff;
   assign mix_b = mix_pend_ff ? take_q_ff : loop_q_ff;
   assign mix_q = mix_f(mix_a, mix_b);

   always_comb begin
      stat            = '0;
      stat.erase_req  = erase_cmd;
      stat.mix_req    = mix_req;
      stat.clear_last = (clr_idx_ff == CLR_LAST);
      stat.mix_last   = (mix_idx_ff == mix_last_ff);
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_len_ff   <= '0;
         take_len_ff   <= '0;
         take_limit_ff <= '0;
         layer_ff      <= '0;
         rec_ff        <= 1'b0;
         pos_ff        <= '0;
         clr_idx_ff    <= '0;
         mix_idx_ff    <= '0;
         mix_pend_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.accept) begin
            loop_len_ff   <= loop_len_in;
            take_len_ff   <= take_len_in;
            take_limit_ff <= take_limit_in;
            layer_ff      <= layer_in;
            rec_ff        <= rec_in;
            pos_ff        <= pos_in;
         end
         if (cmd.clear_step) clr_idx_ff <= stat.clear_last ? '0 : clr_idx_ff + 1'b1;
         if (cmd.accept)        mix_idx_ff <= '0;
         else if (cmd.mix_step) mix_idx_ff <= mix_idx_ff + 1'b1;
         mix_pend_ff <= cmd.mix_step;
         if (cmd.out_load)      rsp_valid_ff <= 1'b1;
         else if (rsp_ready)    rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff   <= sample_in;
         out_en_ff   <= out_en_in;
         rd_addr_ff  <= rd_addr_in;
         mix_last_ff <= mix_last_in;
      end
      mix_wr_idx_ff <= mix_idx_ff;
      if (cmd.out_load) begin
         out_sample_ff <= out_en_ff ? mix_q : '0;
         out_rec_ff    <= rec_ff;
         out_layers_ff <= layer_ff;
      end
   end

   // loop store: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.clear_step)    loop_mem[clr_idx_ff]    <= '0;
      else if (mix_pend_ff)  loop_mem[mix_wr_idx_ff] <= mix_q;
      if (cmd.mix_step)      loop_q_ff <= loop_mem[mix_idx_ff];
      else if (cmd.rd_issue) loop_q_ff <= loop_mem[rd_addr_ff];
   end

   // take store
   always_ff @(posedge clock) begin
      if (cmd.clear_step)             take_mem[clr_idx_ff]         <= '0;
      else if (cmd.accept && append)  take_mem[take_len_ff[AW-1:0]] <= sample_in;
      if (cmd.mix_step)               take_q_ff <= take_mem[mix_idx_ff];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign out_sample   = out_sample_ff;
   assign is_recording = out_rec_ff;
   assign layers_done  = out_layers_ff;

endmodule

@@ hw/rtl/aol_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aol_checker
// Port-level assertions for the looper, bound to the top level.
// ----------------------------------------------------------------------------
module aol_checker import aol_pkg::*; #(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_erase,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SAMPLE_BITS-1:0] rsp_out_sample
);

   // hold off requests while the stores are swept after reset
   a_reset_busy: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("request taken during post-reset clearing pass");

   // one transaction at a time
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready stayed high after accepting a transaction");

   // erase sweeps the stores before anything else is taken
   a_erase_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_erase) |=> ##2 !req_ready)
      else $error("ready returned too early after an erase");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_sample)))
      else $error("stalled response changed or dropped");

endmodule

bind audio_overdub_looper_unit aol_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_aol_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_erase      (req_ch.erase_cmd),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_out_sample (rsp_ch.out_sample)
);

@@ tb/audio_overdub_looper_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_overdub_looper_unit_tb
// Self-checking bench for the overdub looper. A transaction-level looper model
// predicts every response. The expected outputs are queued when a request is
// accepted and compared, field by field, when a response is accepted. The
// store depth is kept small so that buffer capacity, position saturation and
// the clearing passes are all reached in a short run.
// ----------------------------------------------------------------------------
module audio_overdub_looper_unit_tb;
   import aol_pkg::*;

   // Small store: take capacity, play position limit and erase passes stay short
   localparam int STORE_DEPTH = 64;
   localparam int SMP_BITS    = 16;
   localparam int POS_LIMIT   = 4 * STORE_DEPTH - 1;
   localparam int LAYER_LIMIT = 255;
   localparam int SMP_HI      = 32767;
   localparam int SMP_LO      = -32768;
   // Overdub gain 0.707 in Q0.15 with round-half-up offset
   localparam longint GAIN_Q15 = 23167;
   localparam longint HALF_LSB = 16384;
   localparam longint TIMEOUT_NS = 10_000_000;

   typedef struct {
      logic signed [SMP_BITS-1:0] out_sample;
      logic                       is_recording;
      logic [LAYER_BITS-1:0]      layers_done;
   } looper_out_type;

   logic clock;
   logic reset;

   aol_req_if #(.SAMPLE_BITS(SMP_BITS)) req_ch ();
   aol_rsp_if #(.SAMPLE_BITS(SMP_BITS)) rsp_ch ();

   audio_overdub_looper_unit #(
      .MAX_SAMPLES (STORE_DEPTH),
      .SAMPLE_BITS (SMP_BITS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Model state of the looper
   int          loop_mem [STORE_DEPTH];
   int          take_mem [STORE_DEPTH];
   int unsigned loop_len;
   int unsigned take_len;
   int unsigned take_limit;
   int unsigned layer_count;
   bit          recording;
   int unsigned play_pos;

   looper_out_type pending_outputs [$];
   int             fail_count;
   bit             idle_on;
   int             stall_left;

   always #10 clock = ~clock;

   // Put every input at a known level before the first edge
   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.sample_in  = '0;
      req_ch.stop_cmd   = 1'b0;
      req_ch.record_cmd = 1'b0;
      req_ch.erase_cmd  = 1'b0;
      rsp_ch.ready      = 1'b0;
      fail_count        = 0;
      idle_on           = 1'b1;
      stall_left        = 0;
   end

   // Dry/wet mix: floor((gain*(a+b) + half) / 2^15), then clip to the sample range
   function automatic int overdub_mix(int a, int b);
      longint acc;
      acc = (longint'(a) + longint'(b)) * GAIN_Q15 + HALF_LSB;
      acc = acc >>> 15;
      if (acc > SMP_HI) acc = SMP_HI;
      if (acc < SMP_LO) acc = SMP_LO;
      return int'(acc);
   endfunction

   function automatic void clear_looper_model();
      for (int i = 0; i < STORE_DEPTH; i++) begin
         loop_mem[i] = 0;
         take_mem[i] = 0;
      end
      loop_len    = 0;
      take_len    = 0;
      take_limit  = 0;
      layer_count = 0;
      recording   = 1'b0;
      play_pos    = 0;
   endfunction

   // Advance the model by one tick and queue the output it must produce
   function automatic void predict_looper_tick(logic signed [SMP_BITS-1:0] smp,
                                                bit stp, bit rec, bit ers);
      int             s;
      int             mixed;
      looper_out_type o;
      s     = int'(smp);
      mixed = 0;

      // Append the live sample to the take; from the third take on, wrap at the limit
      if (recording) begin
         if (take_len < STORE_DEPTH) begin
            take_mem[take_len] = s;
            take_len++;
         end
         if (layer_count > 1 && take_len >= take_limit) take_len = 0;
      end

      // Stop: close the take, bump the layer count and fold the take into the loop
      if (stp) begin
         recording = 1'b0;
         play_pos  = 0;
         if (layer_count < LAYER_LIMIT) layer_count++;
         if (layer_count == 1) begin
            take_limit = take_len;
            loop_len   = take_len;
         end
         for (int i = 0; i < take_len && i < loop_len; i++)
            loop_mem[i] = overdub_mix(loop_mem[i], take_mem[i]);
         take_len = 0;
      end

      if (rec) recording = 1'b1;

      // Erase keeps loop length, take length, recording and position
      if (ers) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            loop_mem[i] = 0;
            take_mem[i] = 0;
         end
         layer_count = 0;
         take_limit  = 0;
      end

      // Advance playback; short loops never wrap and the position saturates
      if (play_pos < POS_LIMIT) play_pos++;
      if (loop_len >= 2 && play_pos >= loop_len) play_pos = 0;
      if (play_pos >= 1 && play_pos <= loop_len)
         mixed = overdub_mix(s, loop_mem[play_pos - 1]);

      o.out_sample   = mixed[SMP_BITS-1:0];
      o.is_recording = recording;
      o.layers_done  = layer_count[LAYER_BITS-1:0];
      pending_outputs.insert(pending_outputs.size(), o);
   endfunction

   // Drive one transaction, hold it until accepted, then record its expectation
   task automatic send_tick(logic signed [SMP_BITS-1:0] smp, bit stp, bit rec, bit ers);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.sample_in  <= smp;
      req_ch.stop_cmd   <= stp;
      req_ch.record_cmd <= rec;
      req_ch.erase_cmd  <= ers;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_looper_tick(smp, stp, rec, ers);
   endtask

   // Hold off the sender until every outstanding response has arrived
   task automatic drain_outputs();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_outputs.size() != 0) @(posedge clock);
   endtask

   // Mostly full-range noise, with the rails often enough to hit saturation
   function automatic logic signed [SMP_BITS-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return SMP_BITS'(SMP_HI);
         1:       return SMP_BITS'(SMP_LO);
         default: return SMP_BITS'($urandom);
      endcase
   endfunction

   // Check each accepted response against the oldest expectation; stall at random
   always @(posedge clock) begin
      looper_out_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_outputs.size() == 0) begin
            $error("response with no request outstanding: out_sample %0d", rsp_ch.out_sample);
            fail_count++;
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_ch.out_sample !== want.out_sample) begin
               $error("out_sample: expected %0d, actual %0d", want.out_sample,
                      rsp_ch.out_sample);
               fail_count++;
            end
            if (rsp_ch.is_recording !== want.is_recording) begin
               $error("is_recording: expected %0d, actual %0d", want.is_recording,
                      rsp_ch.is_recording);
               fail_count++;
            end
            if (rsp_ch.layers_done !== want.layers_done) begin
               $error("layers_done: expected %0d, actual %0d", want.layers_done,
                      rsp_ch.layers_done);
               fail_count++;
            end
         end
      end
      if (idle_on && stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 3) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Directed: rails, every strobe, repeated record, empty take, all strobes at once
   task automatic test_directed();
      send_tick(SMP_BITS'(SMP_HI), 0, 0, 0);   // empty loop gives silence
      send_tick(16'sd0, 1, 0, 0);               // stop with an empty take
      send_tick(SMP_BITS'(SMP_LO), 0, 0, 1);    // erase
      send_tick(SMP_BITS'(SMP_LO), 0, 1, 0);    // arm recording
      send_tick(SMP_BITS'(SMP_HI), 0, 1, 0);    // repeated record strobe
      send_tick(SMP_BITS'(SMP_LO), 0, 0, 0);
      send_tick(SMP_BITS'(SMP_HI), 0, 0, 0);
      send_tick(16'sd1, 0, 0, 0);
      send_tick(-16'sd1, 0, 0, 0);
      send_tick(16'sd16384, 1, 0, 0);           // first take sets the loop length
      for (int i = 0; i < 8; i++)
         send_tick((i % 2) ? SMP_BITS'(SMP_LO) : SMP_BITS'(SMP_HI), 0, 0, 0);
      send_tick(16'sd100, 1, 1, 0);             // stop and re-arm in one tick
      send_tick(16'sd3000, 0, 0, 0);
      send_tick(-16'sd3000, 0, 0, 0);
      send_tick(SMP_BITS'(SMP_HI), 0, 0, 0);
      send_tick(-16'sd5, 1, 1, 1);              // all strobes at once
      send_tick(16'sd7, 1, 0, 0);
      drain_outputs();
   endtask

   // Well-formed sessions: occasional erase, record, take of random length, stop, play for a while
   task automatic test_overdub_sessions(int n_items);
      int sent;
      int take_n;
      int play_n;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 9) == 0) begin
            send_tick(pick_sample(), 0, 0, 1);
            sent++;
         end
         send_tick(pick_sample(), 0, 1, 0);
         sent++;
         // Now and then overrun the take store to hit its capacity
         take_n = ($urandom_range(0, 7) == 0) ? $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 8)
                                              : $urandom_range(0, 12);
         repeat (take_n) begin
            send_tick(pick_sample(), 0, 0, 0);
            sent++;
         end
         send_tick(pick_sample(), 1, ($urandom_range(0, 3) == 0), 0);
         sent++;
         play_n = $urandom_range(0, 16);
         repeat (play_n) begin
            send_tick(pick_sample(), 0, 0, ($urandom_range(0, 40) == 0));
            sent++;
         end
         if ($urandom_range(0, 4) == 0) drain_outputs();
      end
   endtask

   // One-sample loop never wraps: run the play position into its limit
   task automatic test_position_limit();
      send_tick(pick_sample(), 0, 0, 1);
      send_tick(pick_sample(), 0, 1, 0);
      send_tick(pick_sample(), 1, 0, 0);
      repeat (POS_LIMIT + 6) send_tick(pick_sample(), 0, 0, 0);
   endtask

   // Stack stops past the layer counter's saturation, with short overdubs mixed in
   task automatic test_layer_limit();
      send_tick(pick_sample(), 0, 0, 1);
      send_tick(pick_sample(), 0, 1, 0);
      repeat (10) send_tick(pick_sample(), 0, 0, 0);
      send_tick(pick_sample(), 1, 0, 0);
      repeat (LAYER_LIMIT + 3) begin
         if ($urandom_range(0, 15) == 0) begin
            send_tick(pick_sample(), 0, 1, 0);
            repeat ($urandom_range(0, 6)) send_tick(pick_sample(), 0, 0, 0);
         end
         send_tick(pick_sample(), 1, 0, 0);
      end
   endtask

   // Loose strobes in any combination
   task automatic test_strobe_noise(int n_items);
      repeat (n_items)
         send_tick(pick_sample(), ($urandom_range(0, 4) == 0), ($urandom_range(0, 4) == 0),
                   ($urandom_range(0, 19) == 0));
   endtask

   initial begin
      clear_looper_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_overdub_sessions(280);
      drain_outputs();
      test_position_limit();
      drain_outputs();
      test_layer_limit();
      drain_outputs();
      // Final stretch runs without idling on either side
      idle_on = 1'b0;
      test_strobe_noise(150);

      req_ch.valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      // Let an erase or overdub pass still in flight settle
      repeat (STORE_DEPTH + 20) @(posedge clock);

      if (fail_count == 0) begin
         $display("audio_overdub_looper_unit: match");
      end else begin
         $display("audio_overdub_looper_unit: mismatch");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run as a failure
   initial begin
      #(TIMEOUT_NS);
      $display("audio_overdub_looper_unit: mismatch");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/aol_pkg.sv
hw/rtl/aol_if.sv
hw/rtl/aol_ctrl.sv
hw/rtl/aol_datapath.sv
hw/rtl/audio_overdub_looper_unit.sv
hw/rtl/aol_checker.sv
tb/audio_overdub_looper_unit_tb.sv
